// ===== rtl/core/frpp_pkg.sv =====
`timescale 1ns / 1ps
package frpp_pkg;

  localparam int COORD_W = 32;
  localparam int RAD_W   = 31;
  localparam int MODE_W  = 2;
  localparam int COUNT_W = 11;

  // input mode codes
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  // classified operations handed from front to back
  typedef logic [1:0] op_t;
  localparam op_t OP_NOP   = 2'd0;
  localparam op_t OP_CLEAR = 2'd1;
  localparam op_t OP_LOAD  = 2'd2;
  localparam op_t OP_QUERY = 2'd3;

  typedef struct packed {
    op_t                op;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [RAD_W-1:0]   r;
  } cmd_t;

endpackage

// ===== rtl/core/fixed_radius_point_proximity.sv =====
`timescale 1ns / 1ps
// Fixed-radius proximity store for 3D points (signed Q19.12 coordinates).
// Input channel (in_valid/in_ready): one transaction per item. in_mode selects
// clear (empty the store), load (append in_point_x/y/z) or query (is any stored
// point within in_radius of the given point, by squared distance <= radius^2).
// Result channel (out_valid/out_ready): exactly one transaction per item with
// out_found, out_dropped (load refused, store full) and out_stored_count.
// A front stage classifies items into a two-entry queue; the back stage owns
// the point memory and a pipelined distance unit, so the input keeps taking
// transactions while the back side is busy or the receiver stalls.
// Clear, load, zero-radius query and empty-store query need no scan. A query
// on stored points scans them; the scan reads one stored point per cycle
// through the single memory read port and stops early on the first hit.
// Clear and load sustain one item per cycle while the receiver takes each
// result; a query holds the back stage until its scan ends.
// A stalled receiver holds the result register; the back stage then stops
// taking work and the queue fills before in_ready drops.
// Reset (rst_n low, synchronous) empties the store and the queue; stored
// coordinates are not cleared and need no clearing pass.
module fixed_radius_point_proximity import frpp_pkg::*; #(
  parameter int MAX_PROBES = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [MODE_W-1:0]         in_mode,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  input  logic signed [COORD_W-1:0] in_point_z,
  input  logic [RAD_W-1:0]          in_radius,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_found,
  output logic                      out_dropped,
  output logic [COUNT_W-1:0]        out_stored_count
);

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  frpp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_mode    (in_mode),
    .in_point_x (in_point_x),
    .in_point_y (in_point_y),
    .in_point_z (in_point_z),
    .in_radius  (in_radius),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd)
  );

  frpp_back #(
    .MAX_PROBES (MAX_PROBES)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (cmd_valid),
    .cmd_ready        (cmd_ready),
    .cmd              (cmd),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_found        (out_found),
    .out_dropped      (out_dropped),
    .out_stored_count (out_stored_count)
  );

endmodule

// ===== rtl/core/frpp_front.sv =====
`timescale 1ns / 1ps
module frpp_front import frpp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [MODE_W-1:0]         in_mode,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  input  logic signed [COORD_W-1:0] in_point_z,
  input  logic [RAD_W-1:0]          in_radius,
  output logic                      cmd_valid,
  input  logic                      cmd_ready,
  output cmd_t                      cmd
);

  cmd_t       fifo_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       cls;
  logic       push, pop;

  // classify: zero-radius queries and unused modes become no-ops
  always_comb begin
    cls.x = in_point_x;
    cls.y = in_point_y;
    cls.z = in_point_z;
    cls.r = in_radius;
    unique case (in_mode)
      MODE_CLEAR: cls.op = OP_CLEAR;
      MODE_LOAD:  cls.op = OP_LOAD;
      MODE_QUERY: cls.op = (in_radius == '0) ? OP_NOP : OP_QUERY;
      default:    cls.op = OP_NOP;
    endcase
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = fifo_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== rtl/core/frpp_dist.sv =====
`timescale 1ns / 1ps
module frpp_dist import frpp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 flush,
  input  logic                 pt_valid,
  input  logic [COORD_W-1:0]   sx,
  input  logic [COORD_W-1:0]   sy,
  input  logic [COORD_W-1:0]   sz,
  input  logic [COORD_W-1:0]   qx,
  input  logic [COORD_W-1:0]   qy,
  input  logic [COORD_W-1:0]   qz,
  input  logic [RAD_W-1:0]     r,
  input  logic [2*RAD_W-1:0]   rr,
  output logic                 busy,
  output logic                 res_valid,
  output logic                 hit
);

  localparam int SQ_W  = 2 * RAD_W;
  localparam int SUM_W = SQ_W + 2;

  logic                 v1_r, v2_r, v3_r;
  logic                 far1_r, far2_r, far3_r;
  logic [RAD_W-1:0]     dx1_r, dy1_r, dz1_r;
  logic [SQ_W-1:0]      sqx2_r, sqy2_r, sqz2_r;
  logic [SUM_W-1:0]     sum3_r;
  logic [COORD_W:0]     ax, ay, az;
  logic                 far;

  function automatic logic [COORD_W:0] abs_diff(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    return d[COORD_W] ? (COORD_W+1)'(0) - d : d;
  endfunction

  // stage 1: per-axis distance and far-axis reject
  always_comb begin
    ax  = abs_diff(sx, qx);
    ay  = abs_diff(sy, qy);
    az  = abs_diff(sz, qz);
    far = (ax > {2'b00, r}) || (ay > {2'b00, r}) || (az > {2'b00, r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= pt_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // axis distances fit in RAD_W bits whenever the point is not rejected
  always_ff @(posedge clk) begin
    far1_r <= far;
    dx1_r  <= ax[RAD_W-1:0];
    dy1_r  <= ay[RAD_W-1:0];
    dz1_r  <= az[RAD_W-1:0];
    // stage 2: squares
    far2_r <= far1_r;
    sqx2_r <= SQ_W'(dx1_r) * SQ_W'(dx1_r);
    sqy2_r <= SQ_W'(dy1_r) * SQ_W'(dy1_r);
    sqz2_r <= SQ_W'(dz1_r) * SQ_W'(dz1_r);
    // stage 3: sum
    far3_r <= far2_r;
    sum3_r <= SUM_W'(sqx2_r) + SUM_W'(sqy2_r) + SUM_W'(sqz2_r);
  end

  assign busy      = v1_r || v2_r || v3_r;
  assign res_valid = v3_r;
  assign hit       = !far3_r && (sum3_r <= SUM_W'(rr));

endmodule

// ===== rtl/core/frpp_back.sv =====
`timescale 1ns / 1ps
module frpp_back import frpp_pkg::*; #(
  parameter int MAX_PROBES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  cmd_t               cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_found,
  output logic               out_dropped,
  output logic [COUNT_W-1:0] out_stored_count
);

  localparam int CNT_W  = $clog2(MAX_PROBES + 1);
  localparam int ADDR_W = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                 state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     iss_r, iss_nxt;
  logic                 v0_r;
  logic [3*COORD_W-1:0] mem [MAX_PROBES];
  logic [3*COORD_W-1:0] rd_data_r;
  logic [COORD_W-1:0]   qx_r, qy_r, qz_r;
  logic [RAD_W-1:0]     r_r;
  logic [2*RAD_W-1:0]   rr_r;
  logic                 out_valid_r, found_r, dropped_r;
  logic [COUNT_W-1:0]   cnt_out_r;

  logic                 take, wr_en, rd_en, done, res_load;
  logic                 res_found, res_dropped;
  logic                 dist_busy, dist_valid, dist_hit;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;

  assign cmd_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign take      = cmd_valid && cmd_ready;
  assign rd_en     = (state_r == ST_SCAN) && (iss_r < count_r);
  assign done      = (state_r == ST_SCAN) &&
                     ((dist_valid && dist_hit) || (!rd_en && !v0_r && !dist_busy));

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    iss_nxt     = rd_en ? iss_r + CNT_W'(1) : iss_r;
    wr_en       = 1'b0;
    res_load    = 1'b0;
    res_found   = 1'b0;
    res_dropped = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        iss_nxt = '0;
        if (take) begin
          unique case (cmd.op)
            OP_CLEAR: begin
              count_nxt = '0;
              res_load  = 1'b1;
            end
            OP_LOAD: begin
              res_load = 1'b1;
              if (count_r < CNT_W'(MAX_PROBES)) begin
                wr_en     = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end else begin
                res_dropped = 1'b1;
              end
            end
            OP_QUERY: begin
              if (count_r == '0) begin
                res_load = 1'b1;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            default: res_load = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        if (done) begin
          res_load  = 1'b1;
          res_found = dist_valid && dist_hit;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign cnt_ext = {{COUNT_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      iss_r       <= '0;
      v0_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      iss_r   <= iss_nxt;
      v0_r    <= rd_en && !done;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      found_r   <= res_found;
      dropped_r <= res_dropped;
      cnt_out_r <= cnt_ext[COUNT_W-1:0];
    end
    if (take) begin
      qx_r <= cmd.x;
      qy_r <= cmd.y;
      qz_r <= cmd.z;
      r_r  <= cmd.r;
      rr_r <= (2*RAD_W)'(cmd.r) * (2*RAD_W)'(cmd.r);
    end
  end

  // point store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[ADDR_W-1:0]] <= {cmd.x, cmd.y, cmd.z};
    end
    if (rd_en) begin
      rd_data_r <= mem[iss_r[ADDR_W-1:0]];
    end
  end

  frpp_dist u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .flush     (done),
    .pt_valid  (v0_r),
    .sx        (rd_data_r[3*COORD_W-1:2*COORD_W]),
    .sy        (rd_data_r[2*COORD_W-1:COORD_W]),
    .sz        (rd_data_r[COORD_W-1:0]),
    .qx        (qx_r),
    .qy        (qy_r),
    .qz        (qz_r),
    .r         (r_r),
    .rr        (rr_r),
    .busy      (dist_busy),
    .res_valid (dist_valid),
    .hit       (dist_hit)
  );

  assign out_valid        = out_valid_r;
  assign out_found        = found_r;
  assign out_dropped      = dropped_r;
  assign out_stored_count = cnt_out_r;

endmodule
